[hw/rtl/idbd_pkg.sv]
// ----------------------------------------------------------------------------
// idbd_pkg: shared types and constants for the inclusive day counter
// Date record, field widths and the cumulative month table.
// ----------------------------------------------------------------------------
package idbd_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  // Linear day number and difference, signed
  localparam int unsigned DnW    = 24;
  // Output count width
  localparam int unsigned CountW = 23;

  // Largest count that is passed through unsaturated
  localparam logic signed [DnW-1:0] CountSat = 24'sd4194303;

  // Month three is the first month after a leap day
  localparam logic [MonthW-1:0] MonthMarch = 4'd3;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } date_t;

  // Days before the month in a common year; month 0 sits before January and
  // months 13 to 15 follow December as 31-day months.
  function automatic logic signed [9:0] days_before_month(input logic [MonthW-1:0] m);
    logic signed [9:0] r;
    case (m)
      4'd0:    r = -10'sd31;
      4'd1:    r = 10'sd0;
      4'd2:    r = 10'sd31;
      4'd3:    r = 10'sd59;
      4'd4:    r = 10'sd90;
      4'd5:    r = 10'sd120;
      4'd6:    r = 10'sd151;
      4'd7:    r = 10'sd181;
      4'd8:    r = 10'sd212;
      4'd9:    r = 10'sd243;
      4'd10:   r = 10'sd273;
      4'd11:   r = 10'sd304;
      4'd12:   r = 10'sd334;
      4'd13:   r = 10'sd365;
      4'd14:   r = 10'sd396;
      default: r = 10'sd427;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/idbd_day_num.sv]
// ----------------------------------------------------------------------------
// idbd_day_num: linear Gregorian day number of one date
// 365*year + leap years before year + days before month + day (+1 after Feb).
// ----------------------------------------------------------------------------
module idbd_day_num (
  input  idbd_pkg::date_t                     date_i,
  output logic signed [idbd_pkg::DnW-1:0]     day_num_o
);

  // Reciprocal of 100 scaled by 2^19; exact for every 14-bit year
  localparam logic [12:0] Recip100 = 13'd5243;
  localparam logic [18:0] FracLimit = 19'd2048;

  logic [26:0] prod;
  logic [7:0]  quot100;
  logic        div100;
  logic        div4;
  logic        leap;
  logic [7:0]  ceil100;
  logic [8:0]  ceil100_p3;
  logic [6:0]  ceil400;
  logic [14:0] year_p3;
  logic [12:0] ceil4;
  logic [13:0] leaps;
  logic [22:0] base;
  logic signed [idbd_pkg::DnW-1:0] month_off;
  logic        leap_adj;

  // Split the year into hundreds; a multiple of 100 leaves a tiny fraction
  always_comb begin
    prod    = 27'(date_i.year) * 27'(Recip100);
    quot100 = prod[26:19];
    div100  = prod[18:0] < FracLimit;
    div4    = date_i.year[1:0] == 2'b00;
    leap    = div100 ? (quot100[1:0] == 2'b00) : div4;
  end

  // Count leap years in [0, year) from ceilings of year/4, /100 and /400
  always_comb begin
    year_p3    = 15'(date_i.year) + 15'd3;
    ceil4      = year_p3[14:2];
    ceil100    = quot100 + 8'(!div100);
    ceil100_p3 = 9'(ceil100) + 9'd3;
    ceil400    = ceil100_p3[8:2];
    leaps      = 14'(ceil4) - 14'(ceil100) + 14'(ceil400);
  end

  // Sum the parts
  always_comb begin
    base      = 23'(date_i.year) * 23'd365;
    month_off = idbd_pkg::DnW'(idbd_pkg::days_before_month(date_i.month));
    leap_adj  = leap && (date_i.month >= idbd_pkg::MonthMarch);
    day_num_o = $signed({1'b0, base})
              + $signed({10'b0, leaps})
              + month_off
              + $signed({19'b0, date_i.day})
              + $signed({23'b0, leap_adj});
  end

endmodule

[hw/rtl/idbd_result.sv]
// ----------------------------------------------------------------------------
// idbd_result: difference stage and result register
// Hold both day numbers, subtract, saturate or flag order error, strobe out.
// ----------------------------------------------------------------------------
module idbd_result (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  logic                                  in_order_i,
  input  logic signed [idbd_pkg::DnW-1:0]       dn_start_i,
  input  logic signed [idbd_pkg::DnW-1:0]       dn_end_i,
  output logic                                  done_o,
  output logic signed [idbd_pkg::CountW-1:0]    day_count_o,
  output logic                                  order_error_o
);

  logic                               valid_q;
  logic                               in_order_q;
  logic signed [idbd_pkg::DnW-1:0]    dn_start_q;
  logic signed [idbd_pkg::DnW-1:0]    dn_end_q;
  logic signed [idbd_pkg::DnW-1:0]    diff;
  logic signed [idbd_pkg::CountW-1:0] count_d, count_q;
  logic                               done_q;
  logic                               err_q;

  // Advance the valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= valid_i;
      done_q  <= valid_q;
    end
  end

  // Hold the day numbers
  always_ff @(posedge clk_i) begin
    in_order_q <= in_order_i;
    dn_start_q <= dn_start_i;
    dn_end_q   <= dn_end_i;
  end

  // Inclusive difference, saturated; all ones on order error
  always_comb begin
    diff = dn_end_q - dn_start_q + 24'sd1;
    if (!in_order_q) begin
      count_d = '1;
    end else if (diff > idbd_pkg::CountSat) begin
      count_d = idbd_pkg::CountSat[idbd_pkg::CountW-1:0];
    end else begin
      count_d = diff[idbd_pkg::CountW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    count_q <= count_d;
    err_q   <= !in_order_q;
  end

  assign done_o        = done_q;
  assign day_count_o   = count_q;
  assign order_error_o = err_q;

  // Every transfer in gives a strobe, registered through valid_q and then done_q
  a_strobe_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |=> ##1 done_o)
    else $error("result strobe missing after transfer");

  // An order error always carries the all-ones count
  a_error_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && order_error_o) |-> (day_count_o == '1))
    else $error("order error without all-ones count");

  // Ordered day numbers never give a negative count
  a_count_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && in_order_q && (dn_end_q >= dn_start_q)) |=>
      (done_o && !order_error_o && !day_count_o[idbd_pkg::CountW-1]))
    else $error("ordered dates gave a negative count");

endmodule

[hw/rtl/inclusive_days_between_dates_core.sv]
// ----------------------------------------------------------------------------
// inclusive_days_between_dates_core: inclusive Gregorian day count
// Count days from start to end date, both included; flag start after end.
// ----------------------------------------------------------------------------
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------------
//  request   | start_i, busy_o        | start_day/month/year_i, end_*_i
//  result    | done_o (one-cycle)     | day_count_o, order_error_o
//
//  One request per cycle; busy_o stays low, so every cycle may carry a transfer.
//  A request passes the input register, day-number register and result
//  register; the path is set by the year*reciprocal product in each day number.
//  Reset clears the valid flags only; payload registers hold no reset value.
//  The receiver cannot stall: each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module inclusive_days_between_dates_core #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [idbd_pkg::DayW-1:0]           start_day_i,
  input  logic [idbd_pkg::MonthW-1:0]         start_month_i,
  input  logic [idbd_pkg::YearW-1:0]          start_year_i,
  input  logic [idbd_pkg::DayW-1:0]           end_day_i,
  input  logic [idbd_pkg::MonthW-1:0]         end_month_i,
  input  logic [idbd_pkg::YearW-1:0]          end_year_i,
  output logic                                done_o,
  output logic signed [idbd_pkg::CountW-1:0]  day_count_o,
  output logic                                order_error_o
);

  localparam logic [15:0] MaxYearW = 16'(MAX_YEAR);

  idbd_pkg::date_t start_d, start_q;
  idbd_pkg::date_t end_d, end_q;
  logic            valid_q;
  logic            in_order;
  logic signed [idbd_pkg::DnW-1:0] dn_start;
  logic signed [idbd_pkg::DnW-1:0] dn_end;

  assign busy_o = 1'b0;

  // Saturate years to the top year before any use
  always_comb begin
    start_d.day   = start_day_i;
    start_d.month = start_month_i;
    start_d.year  = ({2'b00, start_year_i} > MaxYearW) ?
                    MaxYearW[idbd_pkg::YearW-1:0] : start_year_i;
    end_d.day     = end_day_i;
    end_d.month   = end_month_i;
    end_d.year    = ({2'b00, end_year_i} > MaxYearW) ?
                    MaxYearW[idbd_pkg::YearW-1:0] : end_year_i;
  end

  // Capture the request on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      start_q <= start_d;
      end_q   <= end_d;
    end
  end

  // Compare on (year, month, day)
  always_comb begin
    in_order = (start_q.year < end_q.year) ||
               ((start_q.year == end_q.year) &&
                ((start_q.month < end_q.month) ||
                 ((start_q.month == end_q.month) && (start_q.day <= end_q.day))));
  end

  idbd_day_num u_dn_start (
    .date_i    (start_q),
    .day_num_o (dn_start)
  );

  idbd_day_num u_dn_end (
    .date_i    (end_q),
    .day_num_o (dn_end)
  );

  idbd_result u_result (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_q),
    .in_order_i    (in_order),
    .dn_start_i    (dn_start),
    .dn_end_i      (dn_end),
    .done_o        (done_o),
    .day_count_o   (day_count_o),
    .order_error_o (order_error_o)
  );

endmodule
